// ----- sv/irr_pkg.sv -----
// ----------------------------------------------------------------------------
// irr_pkg
// Shared constants and types for the in-flight request ring.
// ----------------------------------------------------------------------------
package irr_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int FUNC_W = 2;
   localparam int ID_W   = 64;
   localparam int TAG_W  = 64;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DUMP = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_CLR,
      ST_DUMP_SCAN,
      ST_DUMP_LOAD,
      ST_DUMP_NONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic push;
      logic pop_cmp;
      logic pop_clr;
      logic dump_init;
      logic dump_read;
      logic load_entry;
      logic load_none;
      logic cursor_step;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              occ_any;
      logic              hit;
      logic              rd_last;
      logic              out_free;
   } stat_type;

endpackage

// ----- sv/irr_req_if.sv -----
// ----------------------------------------------------------------------------
// irr_req_if
// Request channel: valid/ready handshake with operation, id and method tag.
// ----------------------------------------------------------------------------
interface irr_req_if import irr_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   txn_id;
   logic [TAG_W-1:0]  method_tag;

   modport source (output valid, func, txn_id, method_tag, input ready);
   modport sink   (input valid, func, txn_id, method_tag, output ready);
endinterface

// ----- sv/irr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// irr_rsp_if
// Result channel: valid/ready handshake with one dumped entry per item.
// ----------------------------------------------------------------------------
interface irr_rsp_if import irr_pkg::*;;
   logic             valid;
   logic             ready;
   logic             entry_valid;
   logic [ID_W-1:0]  entry_id;
   logic [TAG_W-1:0] entry_method;
   logic             last;

   modport source (output valid, entry_valid, entry_id, entry_method, last,
                   input ready);
   modport sink   (input valid, entry_valid, entry_id, entry_method, last,
                   output ready);
endinterface

// ----- sv/irr_ctrl.sv -----
// ----------------------------------------------------------------------------
// irr_ctrl
// Sequencer: decodes one item at a time and steps the datapath through
// push, pop (compare then clear) and the dump walk.
// ----------------------------------------------------------------------------
module irr_ctrl import irr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.func)
               FUNC_POP:  state_in = ST_POP_CLR;
               FUNC_DUMP: state_in = stat.occ_any ? ST_DUMP_SCAN : ST_DUMP_NONE;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_POP_CLR: begin
            state_in = ST_IDLE;
         end
         ST_DUMP_SCAN: begin
            if (stat.hit) begin
               state_in = ST_DUMP_LOAD;
            end
         end
         ST_DUMP_LOAD: begin
            if (stat.out_free) begin
               state_in = stat.rd_last ? ST_IDLE : ST_DUMP_SCAN;
            end
         end
         ST_DUMP_NONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            ctrl.latch = req_valid;
         end
         ST_DECODE: begin
            ctrl.push      = (stat.func == FUNC_PUSH);
            ctrl.pop_cmp   = (stat.func == FUNC_POP);
            ctrl.dump_init = (stat.func == FUNC_DUMP);
         end
         ST_POP_CLR: begin
            ctrl.pop_clr = 1'b1;
         end
         ST_DUMP_SCAN: begin
            ctrl.dump_read   = stat.hit;
            ctrl.cursor_step = !stat.hit;
         end
         ST_DUMP_LOAD: begin
            ctrl.load_entry  = stat.out_free;
            ctrl.cursor_step = stat.out_free;
         end
         ST_DUMP_NONE: begin
            ctrl.load_none = stat.out_free;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

// ----- sv/irr_dpath.sv -----
// ----------------------------------------------------------------------------
// irr_dpath
// Slot storage, pop match, dump cursor and the result register.
// ----------------------------------------------------------------------------
module irr_dpath import irr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   output stat_type          stat,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [ID_W-1:0]   req_txn_id,
   input  logic [TAG_W-1:0]  req_method_tag,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_entry_valid,
   output logic [ID_W-1:0]   rsp_entry_id,
   output logic [TAG_W-1:0]  rsp_entry_method,
   output logic              rsp_last
);

   // latched item
   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   key_ff;
   logic [TAG_W-1:0]  tag_ff;

   // slot state; ids in flops for the parallel pop compare
   logic [ID_W-1:0]   ids_ff [SLOTS];
   logic [TAG_W-1:0]  method_mem [SLOTS];
   logic [SLOTS-1:0]  occ_ff, occ_in;
   logic [SLOT_W-1:0] widx_ff, widx_in;

   // pop and dump working registers
   logic [SLOTS-1:0]  match_ff, match_in;
   logic [SLOTS-1:0]  pending_ff, pending_in;
   logic [SLOT_W-1:0] cursor_ff, cursor_in;
   logic [ID_W-1:0]   rd_id_ff;
   logic [TAG_W-1:0]  rd_method_ff;
   logic              rd_last_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              out_entry_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic [TAG_W-1:0]  out_method_ff;
   logic              out_last_ff;

   logic [SLOTS-1:0]  cur_bit;
   logic [SLOTS-1:0]  low_match;
   logic [SLOTS-1:0]  widx_bit;
   logic [SLOT_W-1:0] cursor_prev;
   logic [SLOT_W-1:0] widx_prev;
   logic              out_free;

   assign cur_bit   = {{(SLOTS-1){1'b0}}, 1'b1} << cursor_ff;
   assign widx_bit  = {{(SLOTS-1){1'b0}}, 1'b1} << widx_ff;
   assign low_match = match_ff & (~match_ff + 1'b1);
   assign out_free  = !out_valid_ff || rsp_ready;

   assign cursor_prev = (cursor_ff == '0) ? SLOT_W'(SLOTS - 1) : cursor_ff - 1'b1;
   assign widx_prev   = (widx_ff == '0) ? SLOT_W'(SLOTS - 1) : widx_ff - 1'b1;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = occ_ff[i] && (ids_ff[i] == key_ff);
      end
   end

   always_comb begin
      occ_in     = occ_ff;
      widx_in    = widx_ff;
      pending_in = pending_ff;
      cursor_in  = cursor_ff;
      if (ctrl.push) begin
         occ_in  = occ_ff | widx_bit;
         widx_in = (widx_ff == SLOT_W'(SLOTS - 1)) ? '0 : widx_ff + 1'b1;
      end
      if (ctrl.pop_clr) begin
         occ_in = occ_ff & ~low_match;
      end
      if (ctrl.dump_init) begin
         pending_in = occ_ff;
         cursor_in  = widx_prev;
      end
      if (ctrl.dump_read) begin
         pending_in = pending_ff & ~cur_bit;
      end
      if (ctrl.cursor_step) begin
         cursor_in = cursor_prev;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctrl.load_entry || ctrl.load_none) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         widx_ff      <= '0;
         pending_ff   <= '0;
         cursor_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         widx_ff      <= widx_in;
         pending_ff   <= pending_in;
         cursor_ff    <= cursor_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         func_ff <= req_func;
         key_ff  <= (req_txn_id == '0) ? ID_W'(1) : req_txn_id;
         tag_ff  <= req_method_tag;
      end
      if (ctrl.pop_cmp) begin
         match_ff <= match_in;
      end
      if (ctrl.push) begin
         ids_ff[widx_ff] <= key_ff;
      end
      if (ctrl.dump_read) begin
         rd_id_ff   <= ids_ff[cursor_ff];
         rd_last_ff <= ((pending_ff & ~cur_bit) == '0);
      end
      if (ctrl.load_entry) begin
         out_entry_ff  <= 1'b1;
         out_id_ff     <= rd_id_ff;
         out_method_ff <= rd_method_ff;
         out_last_ff   <= rd_last_ff;
      end else if (ctrl.load_none) begin
         out_entry_ff  <= 1'b0;
         out_id_ff     <= '0;
         out_method_ff <= '0;
         out_last_ff   <= 1'b1;
      end
   end

   // method tag memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         method_mem[widx_ff] <= tag_ff;
      end
      if (ctrl.dump_read) begin
         rd_method_ff <= method_mem[cursor_ff];
      end
   end

   assign stat.func     = func_ff;
   assign stat.occ_any  = |occ_ff;
   assign stat.hit      = |(pending_ff & cur_bit);
   assign stat.rd_last  = rd_last_ff;
   assign stat.out_free = out_free;

   assign rsp_valid        = out_valid_ff;
   assign rsp_entry_valid  = out_entry_ff;
   assign rsp_entry_id     = out_id_ff;
   assign rsp_entry_method = out_method_ff;
   assign rsp_last         = out_last_ff;

   // a push always leaves its slot occupied
   a_push_occ: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> occ_ff[$past(widx_ff)])
      else $error("pushed slot not marked occupied");

   // a pop frees at most one slot and never fills one
   a_pop_one: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop_clr |=> ($countones($past(occ_ff) & ~occ_ff) <= 1)
                       && (($past(occ_ff) | occ_ff) == $past(occ_ff)))
      else $error("pop changed more than one slot");

   // the dump only reads slots still pending
   a_read_pending: assert property (@(posedge clock) disable iff (reset)
      ctrl.dump_read |-> occ_ff[cursor_ff] && pending_ff[cursor_ff])
      else $error("dump read an empty slot");

   // a result is only loaded into a free register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (ctrl.load_entry || ctrl.load_none) |-> out_free)
      else $error("result register overwritten");

endmodule

// ----- sv/inflight_request_ring.sv -----
// ----------------------------------------------------------------------------
// inflight_request_ring
// Top level of the 16-slot in-flight request recorder.
// ----------------------------------------------------------------------------
// Records up to SLOTS (16) in-flight requests as id / method-tag pairs and
// overwrites the oldest slot once full. A push (func 0) stores the item at
// the write index and gives no result; a pop (func 1) frees the lowest
// numbered slot holding the id and gives no result; a request id of zero is
// taken as 1 in both. A dump (func 2) sends every occupied slot, newest
// first, one result item each, with last set on the final one; an empty
// ring sends one item with entry_valid low and last high. Func code 3 is
// dropped. Items are handled one at a time: each is latched, then decoded;
// a pop then clears (a registered compare of all slots, then the clear),
// and a dump walks a single cursor back over the slots, where each hit
// reads the method tag memory through its registered port before the
// result register is loaded. Output back-pressure stalls a dump only
// while the result register is full. The result register lets the next
// item be taken while the final result still waits on rsp_if.
// ----------------------------------------------------------------------------
module inflight_request_ring import irr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   irr_req_if.sink   req_if,
   irr_rsp_if.source rsp_if
);

   ctrl_type ctrl;
   stat_type stat;
   logic     req_ready;

   // sequencer: one item in flight, steps the datapath
   irr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   assign req_if.ready = req_ready;

   // slots, match logic, dump cursor and result register
   irr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_func         (req_if.func),
      .req_txn_id       (req_if.txn_id),
      .req_method_tag   (req_if.method_tag),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_entry_valid  (rsp_if.entry_valid),
      .rsp_entry_id     (rsp_if.entry_id),
      .rsp_entry_method (rsp_if.entry_method),
      .rsp_last         (rsp_if.last)
   );

endmodule
